/* rtl/core/ouart_pkg.sv */
// shared types and constants for the oversampled uart transceiver
// no dependencies; used by the tx and rx units and the top level
package ouart_pkg;

  localparam int TICKS_PER_BIT_DEF = 3;
  localparam int DATA_BITS         = 8;
  localparam int FRAME_BITS        = DATA_BITS + 2;
  localparam int BIT_CNT_W         = $clog2(FRAME_BITS + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  typedef struct packed {
    logic level;
    logic accepted;
    logic busy;
  } tx_stat_t;

  typedef struct packed {
    logic                 valid;
    logic [DATA_BITS-1:0] data;
    logic                 busy;
  } rx_stat_t;

endpackage

/* rtl/core/ouart_in_if.sv */
// request channel of the transceiver: one oversample tick per request
// no dependencies
interface ouart_in_if;
  logic       valid;
  logic       ready;
  logic       rx_level;
  logic       send_request;
  logic [7:0] tx_byte;

  modport source (output valid, output rx_level, output send_request, output tx_byte,
                  input ready);
  modport sink (input valid, input rx_level, input send_request, input tx_byte,
                output ready);
endinterface

/* rtl/core/ouart_out_if.sv */
// result channel of the transceiver: line and status after each tick
// no dependencies
interface ouart_out_if;
  logic       valid;
  logic       ready;
  logic       tx_level;
  logic       send_accepted;
  logic       tx_busy;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_busy;

  modport source (output valid, output tx_level, output send_accepted, output tx_busy,
                  output rx_valid, output rx_byte, output rx_busy, input ready);
  modport sink (input valid, input tx_level, input send_accepted, input tx_busy,
                input rx_valid, input rx_byte, input rx_busy, output ready);
endinterface

/* rtl/core/ouart_tx.sv */
// transmitter: frame shift register, tick counter and bit counter
// depends on ouart_pkg
module ouart_tx #(
  parameter int TICKS_PER_BIT = ouart_pkg::TICKS_PER_BIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic                                req,
  input  logic [ouart_pkg::DATA_BITS-1:0]     data,
  output ouart_pkg::tx_stat_t                 stat
);
  import ouart_pkg::*;

  localparam int TW = $clog2(TICKS_PER_BIT + 1);

  phase_t                 phase_r, phase_nxt;
  logic [TW-1:0]          cnt_r, cnt_nxt;
  logic [BIT_CNT_W-1:0]   bits_r, bits_nxt;
  logic [FRAME_BITS-1:0]  shift_r, shift_nxt;
  logic                   line_r, line_nxt;
  logic                   accepted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bits_r  <= '0;
      line_r  <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bits_r  <= bits_nxt;
      line_r  <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    line_nxt  = line_r;
    accepted  = 1'b0;
    if (step) begin
      unique case (phase_r)
        PH_RUN: begin
          if (cnt_r == TW'(1)) begin
            line_nxt  = shift_r[0];
            shift_nxt = shift_r >> 1;
            bits_nxt  = bits_r - BIT_CNT_W'(1);
            if (bits_r == BIT_CNT_W'(1)) begin
              // stop period already counts this tick
              phase_nxt = PH_STOP;
              cnt_nxt   = TW'(TICKS_PER_BIT - 1);
            end else begin
              cnt_nxt = TW'(TICKS_PER_BIT);
            end
          end else begin
            cnt_nxt = cnt_r - TW'(1);
          end
        end
        PH_STOP: begin
          if (cnt_r == TW'(1)) begin
            phase_nxt = PH_IDLE;
          end else begin
            cnt_nxt = cnt_r - TW'(1);
          end
        end
        default: begin
          if (req) begin
            // start bit goes out on the accepting tick
            accepted  = 1'b1;
            line_nxt  = 1'b0;
            shift_nxt = {1'b0, 1'b1, data};
            cnt_nxt   = TW'(TICKS_PER_BIT);
            bits_nxt  = BIT_CNT_W'(FRAME_BITS - 1);
            phase_nxt = PH_RUN;
          end
        end
      endcase
    end
  end

  assign stat.level    = line_nxt;
  assign stat.accepted = accepted;
  assign stat.busy     = (phase_nxt != PH_IDLE);

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> line_r)
    else $error("tx line low while idle");

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> cnt_r != '0)
    else $error("tx tick counter zero in active phase");

endmodule

/* rtl/core/ouart_rx.sv */
// receiver: start detect, sample counter, data shift and last byte holder
// depends on ouart_pkg
module ouart_rx #(
  parameter int TICKS_PER_BIT = ouart_pkg::TICKS_PER_BIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                rx_in,
  output ouart_pkg::rx_stat_t stat
);
  import ouart_pkg::*;

  localparam int RW = $clog2(TICKS_PER_BIT + 2);

  phase_t                 phase_r, phase_nxt;
  logic [RW-1:0]          cnt_r, cnt_nxt;
  logic [BIT_CNT_W-1:0]   bits_r, bits_nxt;
  logic [DATA_BITS-1:0]   shift_r, shift_nxt;
  logic [DATA_BITS-1:0]   last_r, last_nxt;
  logic                   got;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bits_r  <= '0;
      last_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bits_r  <= bits_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    last_nxt  = last_r;
    got       = 1'b0;
    if (step) begin
      unique case (phase_r)
        PH_RUN: begin
          if (cnt_r == RW'(1)) begin
            shift_nxt = {rx_in, shift_r[DATA_BITS-1:1]};
            bits_nxt  = bits_r - BIT_CNT_W'(1);
            if (bits_r == BIT_CNT_W'(1)) begin
              phase_nxt = PH_STOP;
              cnt_nxt   = RW'(TICKS_PER_BIT - 1);
              last_nxt  = {rx_in, shift_r[DATA_BITS-1:1]};
              got       = 1'b1;
            end else begin
              cnt_nxt = RW'(TICKS_PER_BIT);
            end
          end else begin
            cnt_nxt = cnt_r - RW'(1);
          end
        end
        PH_STOP: begin
          if (cnt_r == RW'(1)) begin
            phase_nxt = PH_IDLE;
          end else begin
            cnt_nxt = cnt_r - RW'(1);
          end
        end
        default: begin
          // low line while idle: first sample lands mid first data bit
          if (!rx_in) begin
            phase_nxt = PH_RUN;
            cnt_nxt   = RW'(TICKS_PER_BIT + 1);
            bits_nxt  = BIT_CNT_W'(DATA_BITS);
            shift_nxt = '0;
          end
        end
      endcase
    end
  end

  assign stat.valid = got;
  assign stat.data  = last_nxt;
  assign stat.busy  = (phase_nxt != PH_IDLE);

  a_run_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RUN |-> bits_r != '0)
    else $error("rx running with no bits left");

endmodule

/* rtl/core/oversampled_uart_transceiver.sv */
// Full-duplex 8N1 UART stepped by oversample ticks, TICKS_PER_BIT ticks per bit.
// Each request is one tick carrying the sampled receive line and an optional byte
// to send; each request yields exactly one result with the transmit line level and
// the status after that tick. The tx and rx state advance in the cycle the request
// is taken and the result sits in an output register on the next cycle, so a new
// request is taken every clock while the result register is empty or being drained.
// A send is taken only when the transmitter is idle; the start bit appears on the
// same tick. The receiver samples the first data bit TICKS_PER_BIT+1 ticks after
// seeing the line low and has no stop-bit check.
// depends on ouart_pkg, ouart_in_if, ouart_out_if, ouart_tx and ouart_rx
module oversampled_uart_transceiver #(
  parameter int TICKS_PER_BIT = ouart_pkg::TICKS_PER_BIT_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ouart_in_if.sink    in_chan,
  ouart_out_if.source out_chan
);
  import ouart_pkg::*;

  logic                 in_acc;
  logic                 out_valid_r, out_valid_nxt;
  tx_stat_t             tx_stat;
  rx_stat_t             rx_stat;
  tx_stat_t             tx_stat_r;
  rx_stat_t             rx_stat_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  ouart_tx #(.TICKS_PER_BIT(TICKS_PER_BIT)) u_tx (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_acc),
    .req   (in_chan.send_request),
    .data  (in_chan.tx_byte),
    .stat  (tx_stat)
  );

  ouart_rx #(.TICKS_PER_BIT(TICKS_PER_BIT)) u_rx (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_acc),
    .rx_in (in_chan.rx_level),
    .stat  (rx_stat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tx_stat_r <= tx_stat;
      rx_stat_r <= rx_stat;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.tx_level      = tx_stat_r.level;
  assign out_chan.send_accepted = tx_stat_r.accepted;
  assign out_chan.tx_busy       = tx_stat_r.busy;
  assign out_chan.rx_valid      = rx_stat_r.valid;
  assign out_chan.rx_byte       = rx_stat_r.data;
  assign out_chan.rx_busy       = rx_stat_r.busy;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("request taken but no result registered");

endmodule
